// File: src/jkse_pkg.sv
package jkse_pkg;

  // Sizes
  localparam int KEY_MAX_BYTES   = 32;
  localparam int VALUE_MAX_BYTES = 255;
  localparam int KEY_WORDS       = 4;
  localparam int KEY_IDX_W       = $clog2(KEY_MAX_BYTES);
  localparam int QDEPTH          = 4;
  localparam int QAW             = $clog2(QDEPTH);

  // Configuration register indexes
  localparam logic [2:0] REG_KEY_0_7     = 3'd0;
  localparam logic [2:0] REG_KEY_8_15    = 3'd1;
  localparam logic [2:0] REG_KEY_16_23   = 3'd2;
  localparam logic [2:0] REG_KEY_24_31   = 3'd3;
  localparam logic [2:0] REG_KEY_LENGTH  = 3'd4;
  localparam logic [2:0] REG_VALUE_LIMIT = 3'd5;

  localparam logic [5:0] KEY_LENGTH_RESET  = 6'd0;
  localparam logic [7:0] VALUE_LIMIT_RESET = 8'd63;

  // Characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;

  // Result item codes
  localparam logic KIND_VALUE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [1:0] ST_FOUND      = 2'd0;
  localparam logic [1:0] ST_NO_KEY     = 2'd1;
  localparam logic [1:0] ST_NOT_STRING = 2'd2;

  typedef struct packed {
    logic       kind;
    logic [7:0] vbyte;
    logic [1:0] status;
  } res_t;

  // One command per accepted byte that yields results: one or two of them
  typedef struct packed {
    logic [1:0]      cnt;
    res_t [1:0]      res;
  } cmd_t;

  // Handshake between the command queue and its neighbours
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: src/jkse_if.sv
interface jkse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       text_last;

  modport source (output valid, text_byte, text_last, input ready);
  modport sink   (input valid, text_byte, text_last, output ready);
endinterface

interface jkse_out_if;
  logic       valid;
  logic       ready;
  logic       item_kind;
  logic [7:0] value_byte;
  logic [1:0] result_status;
  logic       run_last;

  modport source (output valid, item_kind, value_byte, result_status, run_last, input ready);
  modport sink   (input valid, item_kind, value_byte, result_status, run_last, output ready);
endinterface

interface jkse_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/json_key_string_extractor.sv
// JSON key/string extractor. Feed JSON text one byte per beat on in_ch; a zero byte or a beat
// with text_last ends a text. The block finds the quoted key that equals the programmed key
// bytes (raw comparison, escapes not decoded) followed by a colon, and streams the decoded
// string value on out_ch one byte per beat, then exactly one status beat per text (found, key
// missing, value not a string); run_last marks the final result beat of each input byte. One
// input beat is taken every cycle while the four-entry command queue has room; output runs at
// one result beat per cycle while out_ch is ready, so a byte with two results (value byte plus
// status) holds the output for both beats and the queue absorbs the difference. A result passes
// the queue and then the output register. Program cfg_ch only while idle; it is always ready.
module json_key_string_extractor (
  input  logic        clk,
  input  logic        rst_n,
  jkse_in_if.sink     in_ch,
  jkse_out_if.source  out_ch,
  jkse_cfg_if.sink    cfg_ch
);

  logic              push;
  logic              pop;
  jkse_pkg::cmd_t    push_cmd;
  jkse_pkg::cmd_t    head;
  jkse_pkg::q_stat_t q_stat;

  // Front: take beats, track the scan and build result commands
  jkse_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_ch   (cfg_ch),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Queue: decouple the scan from output back-pressure
  jkse_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // Back: drain each command one result beat at a time
  jkse_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

// File: src/jkse_front.sv
module jkse_front (
  input  logic                clk,
  input  logic                rst_n,
  jkse_in_if.sink             in_ch,
  jkse_cfg_if.sink            cfg_ch,
  input  jkse_pkg::q_stat_t   q_stat,
  output logic                push,
  output jkse_pkg::cmd_t      push_cmd
);

  typedef enum logic [5:0] {
    PH_SEARCH    = 6'b000001,
    PH_IN_KEY    = 6'b000010,
    PH_AFTER_KEY = 6'b000100,
    PH_VALUE_WS  = 6'b001000,
    PH_IN_VALUE  = 6'b010000,
    PH_DONE      = 6'b100000
  } phase_t;

  logic [jkse_pkg::KEY_WORDS-1:0][63:0] key_r;
  logic [5:0]  key_len_r;
  logic [7:0]  limit_r;

  phase_t      phase_r, phase_nxt;
  logic        esc_r, esc_nxt;
  logic        match_r, match_nxt;
  logic [5:0]  kidx_r, kidx_nxt;
  logic [7:0]  vcount_r, vcount_nxt;

  logic        fire;
  logic [7:0]  b;
  logic [5:0]  klen;
  logic [7:0]  lim;
  logic [7:0]  key_byte;
  logic        key_hit;
  logic        is_ws;
  logic        at_limit;
  logic [7:0]  dec;
  logic [1:0]  n;
  jkse_pkg::cmd_t cmd;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !q_stat.full;
  assign fire         = in_ch.valid && in_ch.ready;
  assign b            = in_ch.text_byte;

  // Saturate oversized settings
  assign klen = (key_len_r > 6'(jkse_pkg::KEY_MAX_BYTES)) ?
                6'(jkse_pkg::KEY_MAX_BYTES) : key_len_r;
  assign lim  = (limit_r > 8'(jkse_pkg::VALUE_MAX_BYTES)) ?
                8'(jkse_pkg::VALUE_MAX_BYTES) : limit_r;

  assign key_byte = key_r[kidx_r[jkse_pkg::KEY_IDX_W-1:3]]
                         [{kidx_r[2:0], 3'b000} +: 8];
  assign key_hit  = (kidx_r < klen) && (b == key_byte);
  assign is_ws    = (b == jkse_pkg::CH_SPACE) || (b == jkse_pkg::CH_TAB) ||
                    (b == jkse_pkg::CH_CR) || (b == jkse_pkg::CH_LF);
  assign at_limit = ({1'b0, vcount_r} + 9'd1) >= {1'b0, lim};

  always_comb begin
    if (b == jkse_pkg::CH_N) begin
      dec = jkse_pkg::CH_LF;
    end else if (b == jkse_pkg::CH_R) begin
      dec = jkse_pkg::CH_CR;
    end else if (b == jkse_pkg::CH_T) begin
      dec = jkse_pkg::CH_TAB;
    end else begin
      dec = b;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    esc_nxt    = esc_r;
    match_nxt  = match_r;
    kidx_nxt   = kidx_r;
    vcount_nxt = vcount_r;
    cmd        = '0;
    n          = 2'd0;

    if (fire) begin
      if (b != jkse_pkg::CH_NUL) begin
        unique case (phase_r)
          PH_IN_KEY: begin
            if (!esc_r && b == jkse_pkg::CH_QUOTE) begin
              if (kidx_r != klen) match_nxt = 1'b0;
              phase_nxt = PH_AFTER_KEY;
            end else begin
              esc_nxt = !esc_r && (b == jkse_pkg::CH_BSL);
              if (key_hit) begin
                kidx_nxt = kidx_r + 6'd1;
              end else begin
                match_nxt = 1'b0;
              end
            end
          end
          PH_AFTER_KEY: begin
            if (!is_ws) begin
              if (b == jkse_pkg::CH_COLON && match_r) begin
                phase_nxt = PH_VALUE_WS;
              end else if (b == jkse_pkg::CH_QUOTE) begin
                phase_nxt = PH_IN_KEY;
                esc_nxt   = 1'b0;
                match_nxt = 1'b1;
                kidx_nxt  = 6'd0;
              end else begin
                phase_nxt = PH_SEARCH;
              end
            end
          end
          PH_VALUE_WS: begin
            if (!is_ws) begin
              if (b == jkse_pkg::CH_QUOTE) begin
                phase_nxt  = PH_IN_VALUE;
                esc_nxt    = 1'b0;
                vcount_nxt = 8'd0;
                if (lim == 8'd0) begin
                  cmd.res[n[0]] = '{jkse_pkg::KIND_STATUS, 8'h00, jkse_pkg::ST_FOUND};
                  n = n + 2'd1;
                  phase_nxt = PH_DONE;
                end
              end else begin
                cmd.res[n[0]] = '{jkse_pkg::KIND_STATUS, 8'h00, jkse_pkg::ST_NOT_STRING};
                n = n + 2'd1;
                phase_nxt = PH_DONE;
              end
            end
          end
          PH_IN_VALUE: begin
            if (!esc_r && b == jkse_pkg::CH_BSL) begin
              esc_nxt = 1'b1;
            end else if (!esc_r && b == jkse_pkg::CH_QUOTE) begin
              cmd.res[n[0]] = '{jkse_pkg::KIND_STATUS, 8'h00, jkse_pkg::ST_FOUND};
              n = n + 2'd1;
              phase_nxt = PH_DONE;
            end else begin
              // emit one value byte, decoded if escaped
              esc_nxt = 1'b0;
              cmd.res[n[0]] = '{jkse_pkg::KIND_VALUE, (esc_r ? dec : b), jkse_pkg::ST_FOUND};
              n = n + 2'd1;
              vcount_nxt = vcount_r + 8'd1;
              if (at_limit) begin
                cmd.res[n[0]] = '{jkse_pkg::KIND_STATUS, 8'h00, jkse_pkg::ST_FOUND};
                n = n + 2'd1;
                phase_nxt = PH_DONE;
              end
            end
          end
          PH_DONE: begin
          end
          default: begin
            if (b == jkse_pkg::CH_QUOTE) begin
              phase_nxt = PH_IN_KEY;
              esc_nxt   = 1'b0;
              match_nxt = 1'b1;
              kidx_nxt  = 6'd0;
            end
          end
        endcase
      end

      // End of text: zero byte or last flag
      if (b == jkse_pkg::CH_NUL || in_ch.text_last) begin
        unique case (phase_nxt)
          PH_IN_VALUE: begin
            if (esc_nxt) begin
              cmd.res[n[0]] = '{jkse_pkg::KIND_VALUE, jkse_pkg::CH_BSL, jkse_pkg::ST_FOUND};
              n = n + 2'd1;
            end
            cmd.res[n[0]] = '{jkse_pkg::KIND_STATUS, 8'h00, jkse_pkg::ST_FOUND};
            n = n + 2'd1;
          end
          PH_VALUE_WS: begin
            cmd.res[n[0]] = '{jkse_pkg::KIND_STATUS, 8'h00, jkse_pkg::ST_NOT_STRING};
            n = n + 2'd1;
          end
          PH_DONE: begin
          end
          default: begin
            cmd.res[n[0]] = '{jkse_pkg::KIND_STATUS, 8'h00, jkse_pkg::ST_NO_KEY};
            n = n + 2'd1;
          end
        endcase
        phase_nxt  = PH_SEARCH;
        esc_nxt    = 1'b0;
        match_nxt  = 1'b1;
        kidx_nxt   = 6'd0;
        vcount_nxt = 8'd0;
      end
    end
    cmd.cnt = n;
  end

  assign push     = fire && (n != 2'd0);
  assign push_cmd = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_SEARCH;
      esc_r     <= 1'b0;
      match_r   <= 1'b1;
      kidx_r    <= 6'd0;
      vcount_r  <= 8'd0;
      key_r     <= '0;
      key_len_r <= jkse_pkg::KEY_LENGTH_RESET;
      limit_r   <= jkse_pkg::VALUE_LIMIT_RESET;
    end else begin
      phase_r  <= phase_nxt;
      esc_r    <= esc_nxt;
      match_r  <= match_nxt;
      kidx_r   <= kidx_nxt;
      vcount_r <= vcount_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (cfg_ch.index)
          jkse_pkg::REG_KEY_0_7,
          jkse_pkg::REG_KEY_8_15,
          jkse_pkg::REG_KEY_16_23,
          jkse_pkg::REG_KEY_24_31: key_r[cfg_ch.index[1:0]] <= cfg_ch.data;
          jkse_pkg::REG_KEY_LENGTH: key_len_r <= cfg_ch.data[5:0];
          jkse_pkg::REG_VALUE_LIMIT: limit_r <= cfg_ch.data[7:0];
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// File: src/jkse_cmd_fifo.sv
module jkse_cmd_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  jkse_pkg::cmd_t     push_cmd,
  input  logic               pop,
  output jkse_pkg::cmd_t     head,
  output jkse_pkg::q_stat_t  q_stat
);

  jkse_pkg::cmd_t              mem_r [jkse_pkg::QDEPTH];
  logic [jkse_pkg::QAW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [jkse_pkg::QAW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [jkse_pkg::QAW:0]      count_r, count_nxt;

  assign q_stat.full  = (count_r == (jkse_pkg::QAW+1)'(jkse_pkg::QDEPTH));
  assign q_stat.empty = (count_r == '0);
  assign head         = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (jkse_pkg::QAW+1)'(push) - (jkse_pkg::QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: src/jkse_back.sv
module jkse_back (
  input  logic               clk,
  input  logic               rst_n,
  input  jkse_pkg::cmd_t     head,
  input  jkse_pkg::q_stat_t  q_stat,
  output logic               pop,
  jkse_out_if.source         out_ch
);

  logic           sel_r, sel_nxt;
  logic           valid_r, valid_nxt;
  jkse_pkg::res_t res_r;
  logic           last_r;

  logic           load;
  logic           is_end;

  assign load   = !q_stat.empty && (!valid_r || out_ch.ready);
  assign is_end = sel_r || (head.cnt == 2'd1);
  assign pop    = load && is_end;

  always_comb begin
    sel_nxt   = sel_r;
    valid_nxt = valid_r;
    if (load) begin
      sel_nxt   = !is_end;
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r  <= head.res[sel_r];
      last_r <= is_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      sel_r   <= sel_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.item_kind     = res_r.kind;
  assign out_ch.value_byte    = res_r.vbyte;
  assign out_ch.result_status = res_r.status;
  assign out_ch.run_last      = last_r;

endmodule
